// ===== rtl/lsf_spacing_weight_core_defines.svh =====
// Assertion macros used by the spacing weight datapath.
`ifndef LSF_SPACING_WEIGHT_CORE_DEFINES_SVH
`define LSF_SPACING_WEIGHT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LSF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LSF_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/lsf_pkg.sv =====
package lsf_pkg;

    localparam int LSF_MAX_ELEMENTS = 64;
    localparam int LSF_POS_W        = 16;
    localparam int LSF_GAP_W        = LSF_POS_W + 1;
    localparam int LSF_DEN_W        = LSF_POS_W + 2;
    localparam int LSF_WEIGHT_W     = 32;
    localparam int LSF_INDEX_W      = 6;
    localparam int LSF_CFG_IDX_W    = 2;
    localparam int LSF_DIV_STEPS    = LSF_WEIGHT_W;
    localparam int LSF_DIV_CNT_W    = $clog2(LSF_DIV_STEPS);

    localparam logic [LSF_CFG_IDX_W-1:0] CFG_UPPER_BOUND = 2'd0;
    localparam logic [LSF_CFG_IDX_W-1:0] CFG_NUMERATOR   = 2'd1;
    localparam logic [LSF_CFG_IDX_W-1:0] CFG_BIAS        = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input beat
        logic start;      // load the divider for a new weight
        logic sel_final;  // weight of the just-received final element
        logic step;       // one restoring division step
        logic store;      // move the finished weight to the output register
        logic commit;     // update the held element state
    } t_lsf_cmd;

    typedef struct packed {
        logic have_held;
        logic fin;
        logic out_free;
    } t_lsf_sts;

endpackage

// ===== rtl/lsf_ctrl.sv =====
module lsf_ctrl
    import lsf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_lsf_sts i_sts,
    output t_lsf_cmd o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_STORE  = 2'd3;

    localparam logic [LSF_DIV_CNT_W-1:0] DIV_LAST = LSF_DIV_CNT_W'(LSF_DIV_STEPS - 1);

    logic [1:0]               r_state, n_state;
    logic [LSF_DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                     r_phase, n_phase;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_phase    = r_phase;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_cnt = '0;
                if (i_sts.have_held) begin
                    o_cmd.start = 1'b1;
                    n_phase     = 1'b0;
                    n_state     = S_DIV;
                end else if (i_sts.fin) begin
                    o_cmd.start     = 1'b1;
                    o_cmd.sel_final = 1'b1;
                    n_phase         = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                if (i_sts.out_free) begin
                    o_cmd.store = 1'b1;
                    if (!r_phase && i_sts.fin) begin
                        // The final element's own weight follows the held one.
                        o_cmd.start     = 1'b1;
                        o_cmd.sel_final = 1'b1;
                        n_phase         = 1'b1;
                        n_cnt           = '0;
                        n_state         = S_DIV;
                    end else begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
        end
    end

endmodule

// ===== rtl/lsf_dp.sv =====
`include "lsf_spacing_weight_core_defines.svh"

module lsf_dp
    import lsf_pkg::*;
#(
    parameter int MAX_ELEMENTS = LSF_MAX_ELEMENTS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [LSF_POS_W-1:0]     i_position,
    input  logic                     i_last,
    input  logic                     i_cfg_valid,
    input  logic [LSF_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LSF_POS_W-1:0]     i_cfg_data,
    input  logic                     i_out_ready,
    input  t_lsf_cmd                 i_cmd,
    output t_lsf_sts                 o_sts,
    output logic                     o_out_valid,
    output logic [LSF_WEIGHT_W-1:0]  o_weight,
    output logic [LSF_INDEX_W-1:0]   o_index,
    output logic                     o_saturated,
    output logic                     o_last_res
);

    localparam int CNT_W   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int IDX_EXT = (CNT_W > LSF_INDEX_W) ? CNT_W : LSF_INDEX_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_ELEMENTS - 1);

    // Configuration registers.
    logic [LSF_POS_W-1:0] r_upper_bound;
    logic [LSF_POS_W-1:0] r_numerator;
    logic [LSF_POS_W-1:0] r_bias;

    // Captured input beat.
    logic [LSF_POS_W-1:0] r_pos;
    logic                 r_fin;

    // Held element state.
    logic [LSF_POS_W-1:0]        r_held_pos;
    logic signed [LSF_GAP_W-1:0] r_held_left;
    logic                        r_have_held;
    logic [CNT_W-1:0]            r_count;

    // Divider.
    logic [LSF_WEIGHT_W-1:0] r_quo;
    logic [LSF_GAP_W-1:0]    r_rem;
    logic [LSF_GAP_W-1:0]    r_den;
    logic                    r_sat;
    logic [CNT_W-1:0]        r_res_idx;
    logic                    r_res_last;

    // Output register.
    logic                    r_out_valid;
    logic [LSF_WEIGHT_W-1:0] r_out_weight;
    logic [CNT_W-1:0]        r_out_idx;
    logic                    r_out_sat;
    logic                    r_out_last;

    logic signed [LSF_GAP_W-1:0] diff;
    logic signed [LSF_GAP_W-1:0] left_cur;
    logic signed [LSF_GAP_W-1:0] right_fin;
    logic signed [LSF_GAP_W-1:0] left_op;
    logic signed [LSF_GAP_W-1:0] right_op;
    logic signed [LSF_GAP_W-1:0] gap;
    logic signed [LSF_DEN_W-1:0] den;
    logic [CNT_W-1:0]            idx_cur;
    logic [LSF_DEN_W-1:0]        trial;
    logic [LSF_DEN_W-1:0]        trial_sub;
    logic                        trial_ge;
    logic                        out_free;
    logic [IDX_EXT-1:0]          idx_ext;

    always_comb begin
        diff      = $signed({1'b0, r_pos}) - $signed({1'b0, r_held_pos});
        left_cur  = r_have_held ? diff : $signed({1'b0, r_pos});
        right_fin = $signed({1'b0, r_upper_bound}) - $signed({1'b0, r_pos});
        idx_cur   = r_have_held ? ((r_count == CNT_LAST) ? '0 : r_count + 1'b1) : '0;
        left_op   = i_cmd.sel_final ? left_cur : r_held_left;
        right_op  = i_cmd.sel_final ? right_fin : diff;
        gap       = (right_op < left_op) ? right_op : left_op;
        den       = $signed({gap[LSF_GAP_W-1], gap}) + $signed({2'b00, r_bias});
        trial     = {r_rem, r_quo[LSF_WEIGHT_W-1]};
        trial_sub = trial - {1'b0, r_den};
        trial_ge  = (trial >= {1'b0, r_den});
        out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_bound <= '1;
            r_numerator   <= LSF_POS_W'(1);
            r_bias        <= LSF_POS_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_UPPER_BOUND: r_upper_bound <= i_cfg_data;
                CFG_NUMERATOR:   r_numerator   <= i_cfg_data;
                CFG_BIAS:        r_bias        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos <= i_position;
            r_fin <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_pos  <= '0;
            r_held_left <= '0;
            r_have_held <= 1'b0;
            r_count     <= '0;
        end else if (i_cmd.commit) begin
            if (r_fin) begin
                r_held_pos  <= '0;
                r_held_left <= '0;
                r_have_held <= 1'b0;
                r_count     <= '0;
            end else begin
                r_held_pos  <= r_pos;
                r_held_left <= left_cur;
                r_have_held <= 1'b1;
                r_count     <= idx_cur;
            end
        end
    end

    // Restoring division of numerator*65536 by the 17-bit denominator.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_quo      <= {r_numerator, {(LSF_WEIGHT_W - LSF_POS_W){1'b0}}};
            r_rem      <= '0;
            r_den      <= den[LSF_GAP_W-1:0];
            r_sat      <= den[LSF_DEN_W-1] || (den == '0);
            r_res_idx  <= i_cmd.sel_final ? idx_cur : r_count;
            r_res_last <= i_cmd.sel_final;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[LSF_WEIGHT_W-2:0], trial_ge};
            r_rem <= trial_ge ? trial_sub[LSF_GAP_W-1:0] : trial[LSF_GAP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.store) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_out_weight <= r_sat ? '1 : r_quo;
            r_out_idx    <= r_res_idx;
            r_out_sat    <= r_sat;
            r_out_last   <= r_res_last;
        end
    end

    assign idx_ext = IDX_EXT'(r_out_idx);

    assign o_sts.have_held = r_have_held;
    assign o_sts.fin       = r_fin;
    assign o_sts.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_weight    = r_out_weight;
    assign o_index     = idx_ext[LSF_INDEX_W-1:0];
    assign o_saturated = r_out_sat;
    assign o_last_res  = r_out_last;

    `LSF_ASSERT(a_count_needs_held, i_clk, i_rst_n, (r_count != '0) |-> r_have_held, "nonzero element count without a held element")
    `LSF_ASSERT(a_sat_all_ones, i_clk, i_rst_n, (r_out_valid && r_out_sat) |-> (r_out_weight == '1), "saturated weight is not all ones")
    `LSF_ASSERT_NEXT(a_final_clears, i_clk, i_rst_n, i_cmd.store && r_res_last, !r_have_held && (r_count == '0), "held state not cleared after final weight")

endmodule

// ===== rtl/lsf_spacing_weight_core.sv =====
// Spacing weight engine for an ordered position vector.
// Input channel (i_in_valid / o_in_ready) takes one element per beat, with
// i_last on the final element. Output channel (o_out_valid / i_out_ready)
// delivers one weight per beat with its element index, a saturation flag
// and o_last_res on the weight of the final element.
// The configuration channel (i_cfg_valid / o_cfg_ready) is always ready and
// writes upper_bound, numerator or bias by index; write only while idle.
// Each weight comes from a shared 32-step restoring divider, one quotient
// bit per cycle. An element that yields one weight passes through setup,
// the divide steps and a store into the output register after its beat is
// accepted, and the next beat can be taken once the store is done.
// The final element of a longer vector yields two weights, the held
// element's and then its own. The first element of a longer vector
// yields no weight and frees the input without using the divider.
// One element is processed at a time; the input is ready again once its
// weights are in the output register. A stalled receiver holds the output
// register, and a following weight waits in the divider until it drains.
// Synchronous reset clears the held element, the output register and the
// controller, and restores upper_bound 65535, numerator 1 and bias 1.
module lsf_spacing_weight_core
    import lsf_pkg::*;
#(
    parameter int MAX_ELEMENTS = LSF_MAX_ELEMENTS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [LSF_POS_W-1:0]     i_position,
    input  logic                     i_last,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [LSF_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LSF_POS_W-1:0]     i_cfg_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [LSF_WEIGHT_W-1:0]  o_weight,
    output logic [LSF_INDEX_W-1:0]   o_index,
    output logic                     o_saturated,
    output logic                     o_last_res
);

    t_lsf_cmd cmd;
    t_lsf_sts sts;

    assign o_cfg_ready = 1'b1;

    lsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lsf_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_position  (i_position),
        .i_last      (i_last),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_weight    (o_weight),
        .o_index     (o_index),
        .o_saturated (o_saturated),
        .o_last_res  (o_last_res)
    );

endmodule
